### sv/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define AST_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/ddo_pkg.sv
// ----------------------------------------------------------------------------
// ddo_pkg
// shared types, constants and the cordic arctangent table for the odometry
// ----------------------------------------------------------------------------
package ddo_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int FRAC_BITS    = 16;
  localparam int DIV_W        = 51;
  localparam int CNT_W        = 6;
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_W - 1);
  localparam logic [CNT_W-1:0] ROT_LAST = CNT_W'(CORDIC_STEPS - 1);

  localparam logic [30:0] GAIN_Q30    = 31'd652032874;
  localparam logic [29:0] INV_2PI_Q32 = 30'd683565276;

  localparam logic [15:0] RADIUS_RESET = 16'd1835;
  localparam logic [15:0] SEP_RESET    = 16'd4096;

  localparam logic [7:0] REG_RADIUS = 8'd0;
  localparam logic [7:0] REG_SEP    = 8'd1;

  typedef enum logic [3:0] {
    OP_NONE, OP_PRIME, OP_DELTA, OP_MUL, OP_PREP, OP_DIV, OP_ANG,
    OP_BAMMUL, OP_LOAD1, OP_ROT, OP_POS, OP_LOAD2, OP_EMIT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [4:0] step;
  } cmd_t;

  typedef struct packed {
    logic primed;
    logic out_busy;
  } status_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] index;
    logic [15:0] data;
  } cfg_wr_t;

  // arctangent of 2^-i as binary angle
  function automatic logic [31:0] atan_bam(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

### sv/diff_drive_odometry_top.sv
// ----------------------------------------------------------------------------
// diff_drive_odometry_top
// differential drive odometry: wheel angles in, pose and step values out
// ----------------------------------------------------------------------------
// One item is worked at a time: the divide for the heading change runs one
// quotient bit a cycle, and one shared cordic unit runs 16 steps twice
// (position rotation, then yaw quaternion). The first item after reset only
// stores the angles, and the next item can be transferred in the cycle after.
// Register writes are taken on any cycle; cfg_ready is always high. A finished
// result waits in the output register while the next item is transferred in.
module diff_drive_odometry_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] left_wheel_angle,
  input  logic signed [31:0] right_wheel_angle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] pose_x,
  output logic signed [31:0] pose_y,
  output logic [31:0]        heading_angle,
  output logic signed [15:0] quat_z,
  output logic signed [15:0] quat_w,
  output logic signed [31:0] linear_step,
  output logic signed [31:0] angular_step,
  output logic               turning,
  output logic [31:0]        sequence_number
);
  import ddo_pkg::*;

  cmd_t    cmd;
  status_t status;
  cfg_wr_t cfg;

  assign cfg_ready = 1'b1;
  assign cfg.valid = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // sequencer
  ddo_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // arithmetic and state
  ddo_datapath u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .cfg               (cfg),
    .left_wheel_angle  (left_wheel_angle),
    .right_wheel_angle (right_wheel_angle),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .pose_x            (pose_x),
    .pose_y            (pose_y),
    .heading_angle     (heading_angle),
    .quat_z            (quat_z),
    .quat_w            (quat_w),
    .linear_step       (linear_step),
    .angular_step      (angular_step),
    .turning           (turning),
    .sequence_number   (sequence_number)
  );

endmodule

### sv/ddo_ctrl.sv
// ----------------------------------------------------------------------------
// ddo_ctrl
// sequencer: prime or delta, multiply, divide, two cordic runs, emit
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module ddo_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  ddo_pkg::status_t status,
  output ddo_pkg::cmd_t    cmd
);
  import ddo_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_PREP, S_DIV, S_ANG, S_BAMMUL, S_LOAD1, S_ROT1,
    S_POS, S_LOAD2, S_ROT2, S_EMIT
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;

  assign in_stall = (state != S_IDLE);

  // command decode
  always_comb begin
    cmd.op   = OP_NONE;
    cmd.step = cnt[4:0];
    unique case (state)
      S_IDLE: begin
        if (in_valid) cmd.op = status.primed ? OP_DELTA : OP_PRIME;
      end
      S_MUL:    cmd.op = OP_MUL;
      S_PREP:   cmd.op = OP_PREP;
      S_DIV:    cmd.op = OP_DIV;
      S_ANG:    cmd.op = OP_ANG;
      S_BAMMUL: cmd.op = OP_BAMMUL;
      S_LOAD1:  cmd.op = OP_LOAD1;
      S_ROT1:   cmd.op = OP_ROT;
      S_POS:    cmd.op = OP_POS;
      S_LOAD2:  cmd.op = OP_LOAD2;
      S_ROT2:   cmd.op = OP_ROT;
      S_EMIT: begin
        if (!status.out_busy) cmd.op = OP_EMIT;
      end
      default:  cmd.op = OP_NONE;
    endcase
  end

  // state and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid && status.primed) state <= S_MUL;
        end
        S_MUL:  state <= S_PREP;
        S_PREP: begin
          state <= S_DIV;
          cnt   <= '0;
        end
        S_DIV: begin
          if (cnt == DIV_LAST) state <= S_ANG;
          else cnt <= cnt + 1'b1;
        end
        S_ANG:    state <= S_BAMMUL;
        S_BAMMUL: state <= S_LOAD1;
        S_LOAD1: begin
          state <= S_ROT1;
          cnt   <= '0;
        end
        S_ROT1: begin
          if (cnt == ROT_LAST) state <= S_POS;
          else cnt <= cnt + 1'b1;
        end
        S_POS:  state <= S_LOAD2;
        S_LOAD2: begin
          state <= S_ROT2;
          cnt   <= '0;
        end
        S_ROT2: begin
          if (cnt == ROT_LAST) state <= S_EMIT;
          else cnt <= cnt + 1'b1;
        end
        S_EMIT: begin
          if (!status.out_busy) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `AST_NEXT(a_div_end, state == S_DIV && cnt == DIV_LAST, state == S_ANG, "divide overran")
  `AST_NEXT(a_prime_idle, in_valid && !in_stall && !status.primed, state == S_IDLE, "prime item started work")
  `AST_IMPL(a_emit_free, cmd.op == OP_EMIT, !status.out_busy, "emit over pending result")

endmodule

### sv/ddo_datapath.sv
// ----------------------------------------------------------------------------
// ddo_datapath
// wheel deltas, step products, restoring divider, shared cordic, pose state
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module ddo_datapath (
  input  logic                clk,
  input  logic                rst,
  input  ddo_pkg::cmd_t       cmd,
  output ddo_pkg::status_t    status,
  input  ddo_pkg::cfg_wr_t    cfg,
  input  logic signed [31:0]  left_wheel_angle,
  input  logic signed [31:0]  right_wheel_angle,
  input  logic                out_stall,
  output logic                out_valid,
  output logic signed [31:0]  pose_x,
  output logic signed [31:0]  pose_y,
  output logic [31:0]         heading_angle,
  output logic signed [15:0]  quat_z,
  output logic signed [15:0]  quat_w,
  output logic signed [31:0]  linear_step,
  output logic signed [31:0]  angular_step,
  output logic                turning,
  output logic [31:0]         sequence_number
);
  import ddo_pkg::*;

  localparam logic signed [50:0] MAX32_51 = 51'sd2147483647;
  localparam logic signed [50:0] MIN32_51 = -51'sd2147483648;
  localparam logic signed [63:0] MAX16_64 = 64'sd32767;
  localparam logic signed [63:0] MIN16_64 = -64'sd32768;

  // configuration and state
  logic [15:0]        radius_q16, wheel_separation;
  logic               primed;
  logic [31:0]        prev_left, prev_right;
  logic [31:0]        acc_x, acc_y, acc_heading, emit_count;

  // step registers
  logic signed [32:0] dl, dr;
  logic signed [50:0] prod_s, prod_d;
  logic signed [31:0] lin, ang;
  logic               ang_neg;
  logic [DIV_W-1:0]   div_num;
  logic [16:0]        div_rem, div_den;
  logic signed [62:0] gmul, bam_prod;
  logic signed [63:0] cx, cy;
  logic signed [33:0] cz;

  // combinational helpers
  logic signed [33:0] sum_w, diff_w;
  logic [15:0]        sep_eff;
  logic signed [50:0] lin_r;
  logic [50:0]        mag;
  logic [17:0]        trial;
  logic               q_bit;
  logic [31:0]        q_lo;
  logic               q_big;
  logic signed [62:0] bam_r;
  logic signed [63:0] ld_x;
  logic [31:0]        ld_a, ld_t, ld_af;
  logic signed [63:0] xs, ys, px, py, qx, qy;
  logic [31:0]        at;

  assign sum_w   = {dr[32], dr} + {dl[32], dl};
  assign diff_w  = {dr[32], dr} - {dl[32], dl};
  assign sep_eff = (wheel_separation == '0) ? 16'd1 : wheel_separation;
  assign lin_r   = (prod_s + 51'sd65536) >>> 17;
  assign mag     = prod_d[50] ? 51'(-prod_d) : 51'(prod_d);

  // one restoring divide step
  assign trial = {div_rem, div_num[DIV_W-1]};
  assign q_bit = (trial >= {1'b0, div_den});
  assign q_lo  = div_num[31:0];
  assign q_big = (div_num[DIV_W-1:32] != '0);

  assign bam_r = (bam_prod + (63'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;

  // cordic load source with half-turn fold
  always_comb begin
    if (cmd.op == OP_LOAD1) begin
      ld_x = 64'(gmul);
      ld_a = acc_heading;
    end else begin
      ld_x = 64'(signed'({1'b0, GAIN_Q30}));
      ld_a = {1'b0, acc_heading[31:1]};
    end
    ld_t  = ld_a + 32'h4000_0000;
    ld_af = ld_t[31] ? (ld_a + 32'h8000_0000) : ld_a;
  end

  assign xs = cx >>> cmd.step;
  assign ys = cy >>> cmd.step;
  assign at = atan_bam(cmd.step);
  assign px = (cx + (64'sd1 <<< 29)) >>> 30;
  assign py = (cy + (64'sd1 <<< 29)) >>> 30;
  assign qx = (cx + 64'sd16384) >>> 15;
  assign qy = (cy + 64'sd16384) >>> 15;

  assign status.primed   = primed;
  assign status.out_busy = out_valid && out_stall;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      radius_q16       <= RADIUS_RESET;
      wheel_separation <= SEP_RESET;
      primed           <= 1'b0;
      prev_left        <= '0;
      prev_right       <= '0;
      acc_x            <= '0;
      acc_y            <= '0;
      acc_heading      <= '0;
      emit_count       <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg.valid) begin
        if (cfg.index == REG_RADIUS) radius_q16 <= cfg.data;
        if (cfg.index == REG_SEP) wheel_separation <= cfg.data;
      end
      if (out_valid && !out_stall && cmd.op != OP_EMIT) out_valid <= 1'b0;
      case (cmd.op)
        OP_PRIME: begin
          prev_left  <= left_wheel_angle;
          prev_right <= right_wheel_angle;
          primed     <= 1'b1;
        end
        OP_DELTA: begin
          prev_left  <= left_wheel_angle;
          prev_right <= right_wheel_angle;
        end
        OP_LOAD1: acc_heading <= acc_heading + bam_r[31:0];
        OP_POS: begin
          acc_x <= acc_x + px[31:0];
          acc_y <= acc_y + py[31:0];
        end
        OP_EMIT: begin
          out_valid  <= 1'b1;
          emit_count <= emit_count + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // arithmetic registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_DELTA: begin
        dl <= {left_wheel_angle[31], left_wheel_angle} - {prev_left[31], prev_left};
        dr <= {right_wheel_angle[31], right_wheel_angle} - {prev_right[31], prev_right};
      end
      OP_MUL: begin
        prod_s <= sum_w * signed'({1'b0, radius_q16});
        prod_d <= diff_w * signed'({1'b0, radius_q16});
      end
      OP_PREP: begin
        if (lin_r > MAX32_51) lin <= 32'sh7fff_ffff;
        else if (lin_r < MIN32_51) lin <= 32'sh8000_0000;
        else lin <= lin_r[31:0];
        ang_neg <= prod_d[50];
        div_num <= mag + DIV_W'(sep_eff);
        div_den <= {sep_eff, 1'b0};
        div_rem <= '0;
      end
      OP_DIV: begin
        div_rem <= q_bit ? 17'(trial - {1'b0, div_den}) : trial[16:0];
        div_num <= {div_num[DIV_W-2:0], q_bit};
      end
      OP_ANG: begin
        if (ang_neg) begin
          if (q_big || q_lo > 32'h8000_0000) ang <= 32'sh8000_0000;
          else ang <= signed'(-q_lo);
        end else begin
          if (q_big || q_lo[31]) ang <= 32'sh7fff_ffff;
          else ang <= signed'(q_lo);
        end
      end
      OP_BAMMUL: begin
        bam_prod <= ang * signed'({1'b0, INV_2PI_Q32});
        gmul     <= lin * signed'({1'b0, GAIN_Q30});
      end
      OP_LOAD1, OP_LOAD2: begin
        cx <= ld_t[31] ? -ld_x : ld_x;
        cy <= '0;
        cz <= {{2{ld_af[31]}}, ld_af};
      end
      OP_ROT: begin
        if (!cz[33]) begin
          cx <= cx - ys;
          cy <= cy + xs;
          cz <= cz - signed'({2'b00, at});
        end else begin
          cx <= cx + ys;
          cy <= cy - xs;
          cz <= cz + signed'({2'b00, at});
        end
      end
      OP_EMIT: begin
        pose_x          <= acc_x;
        pose_y          <= acc_y;
        heading_angle   <= acc_heading;
        linear_step     <= lin;
        angular_step    <= ang;
        turning         <= (ang != '0);
        sequence_number <= emit_count;
        if (qy > MAX16_64) quat_z <= 16'sh7fff;
        else if (qy < MIN16_64) quat_z <= 16'sh8000;
        else quat_z <= qy[15:0];
        if (qx > MAX16_64) quat_w <= 16'sh7fff;
        else if (qx < MIN16_64) quat_w <= 16'sh8000;
        else quat_w <= qx[15:0];
      end
      default: ;
    endcase
  end

  `AST_NEXT(a_emit_valid, cmd.op == OP_EMIT, out_valid, "result not presented")
  `AST_IMPL(a_turn_flag, out_valid, turning == (angular_step != '0), "turning flag mismatch")
  `AST_NEXT(a_prime_set, cmd.op == OP_PRIME, primed, "primed not set")

endmodule
